// ===== src/fbm_pkg.sv =====
// Shared constants, types and helpers for the frame bit-rate meter.
// No dependencies; every other file of the block but fbm_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package fbm_pkg;

  // History ring depth, a power of two
  localparam int WINDOW_DEPTH = 1024;
  // Short-term window in seconds, 1..4
  localparam int DURATION     = 1;
  localparam int HIST_AW      = $clog2(WINDOW_DEPTH);

  localparam int BITS_W  = 26;
  localparam int RATE_W  = 31;
  localparam int INDEX_W = 32;
  localparam int FR_W    = 8;
  localparam int WIN_W   = FR_W + $clog2(DURATION + 1);

  // Serial arithmetic unit widths
  localparam int ACC_W   = 72;               // accumulator / dividend / quotient
  localparam int MCAND_W = ACC_W - FR_W;     // multiplicand
  localparam int DIV_W   = INDEX_W + 1;      // divisor / left-aligned multiplier
  localparam int ST_W    = RATE_W + 3;       // short-term sum
  localparam int CNT_W   = $clog2(ACC_W + 1);

  localparam logic [FR_W-1:0]   FR_RESET = FR_W'(30);
  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

  localparam logic [CNT_W-1:0] MUL1_STEPS = CNT_W'(RATE_W);
  localparam logic [CNT_W-1:0] DIV1_STEPS = CNT_W'(RATE_W + INDEX_W);
  localparam logic [CNT_W-1:0] MUL2_STEPS = CNT_W'(FR_W);
  localparam logic [CNT_W-1:0] DIV2_STEPS = CNT_W'(ACC_W);
  localparam logic [CNT_W-1:0] SDIV_STEPS = CNT_W'(ST_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL1,
    ST_DIV1,
    ST_MUL2,
    ST_DIV2,
    ST_SDIV,
    ST_DONE
  } fbm_state_t;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } fbm_op_t;

  typedef struct packed {
    logic             start;
    fbm_op_t          op;
    logic [CNT_W-1:0] steps;
    logic [ACC_W-1:0] opa;
    logic [DIV_W-1:0] opb;
  } fbm_cmd_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [ACC_W-1:0] value;
  } fbm_res_t;

  function automatic logic [RATE_W-1:0] fbm_sat(input logic [ACC_W-1:0] v);
    return (|v[ACC_W-1:RATE_W]) ? RATE_MAX : v[RATE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/fbm_if.sv =====
// Valid/ready channel interfaces for frame items and result items.
// Depends on fbm_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface fbm_in_if import fbm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BITS_W-1:0] frame_bits;

  modport source (output valid, output frame_bits, input ready);
  modport sink   (input valid, input frame_bits, output ready);
endinterface

interface fbm_out_if import fbm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] frame_index;
  logic [RATE_W-1:0]  short_term_rate;
  logic [RATE_W-1:0]  average_rate;

  modport source (output valid, output frame_index, output short_term_rate,
                  output average_rate, input ready);
  modport sink   (input valid, input frame_index, input short_term_rate,
                  input average_rate, output ready);
endinterface

`default_nettype wire

// ===== src/fbm_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Holds the frame bit-count history ring; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fbm_ram #(
  parameter int DW = 26,
  parameter int AW = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/fbm_serial_alu.sv =====
// Shared bit-serial arithmetic unit: shift-add multiply (one multiplier bit
// per cycle) and restoring divide (one quotient bit per cycle). Uses fbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbm_serial_alu import fbm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire fbm_cmd_t cmd,
  output fbm_res_t      res
);

  logic [ACC_W-1:0]   x_r, x_nxt;
  logic [DIV_W-1:0]   r_r, r_nxt;
  logic [DIV_W-1:0]   b_r, b_nxt;
  logic [MCAND_W-1:0] m_r, m_nxt;
  fbm_op_t            op_r, op_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;

  logic [DIV_W:0]     r_sh;
  logic               ge;

  // Partial remainder with the next dividend bit shifted in
  assign r_sh = {r_r, x_r[ACC_W-1]};
  assign ge   = r_sh >= {1'b0, b_r};

  always_comb begin
    x_nxt    = x_r;
    r_nxt    = r_r;
    b_nxt    = b_r;
    m_nxt    = m_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      x_nxt    = (cmd.op == OP_DIV) ? cmd.opa : '0;
      m_nxt    = cmd.opa[MCAND_W-1:0];
      b_nxt    = cmd.opb;
      r_nxt    = '0;
      op_nxt   = cmd.op;
      cnt_nxt  = cmd.steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      unique case (op_r)
        OP_MUL: begin
          // multiplier is left-aligned: consume its top bit each cycle
          x_nxt = {x_r[ACC_W-2:0], 1'b0} + (b_r[DIV_W-1] ? ACC_W'(m_r) : '0);
          b_nxt = {b_r[DIV_W-2:0], 1'b0};
        end
        OP_DIV: begin
          x_nxt = {x_r[ACC_W-2:0], ge};
          r_nxt = ge ? DIV_W'(r_sh - {1'b0, b_r}) : r_sh[DIV_W-1:0];
        end
        default: begin
          x_nxt = x_r;
        end
      endcase
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r   <= OP_MUL;
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    r_r <= r_nxt;
    b_r <= b_nxt;
    m_r <= m_nxt;
  end

  assign res.busy  = busy_r;
  assign res.done  = done_r;
  assign res.value = x_r;

endmodule

`default_nettype wire

// ===== src/frame_bitrate_meter.sv =====
// Frame bit-rate meter: short-term and cumulative average bit rate per frame.
// Each item goes through the bit-serial unit as a multiply, a divide, a multiply and
// a divide, plus one more divide when the window spans more than one second, before
// its result is valid. A new item is taken only once the last result has moved to
// the output register. Reset (synchronous, active low) clears the counters and
// rates and sets frame_rate to 30; history needs no clear.
`timescale 1ns / 1ps
`default_nettype none

module frame_bitrate_meter import fbm_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [FR_W-1:0] cfg_wdata,
  fbm_in_if.sink               in_ch,
  fbm_out_if.source            out_ch
);

  fbm_state_t state_r, state_nxt;

  logic [FR_W-1:0]    frame_rate_r;
  logic [INDEX_W-1:0] frame_count_r, frame_count_nxt;
  logic [RATE_W-1:0]  short_r, short_nxt;
  logic [RATE_W-1:0]  avg_r, avg_nxt;

  logic [BITS_W-1:0]  bits_r, bits_nxt;
  logic [FR_W-1:0]    f_r, f_nxt;
  logic [INDEX_W-1:0] p_r, p_nxt;
  logic [DIV_W-1:0]   c_r, c_nxt;
  logic               sub_r, sub_nxt;
  logic [ST_W-1:0]    st_r, st_nxt;
  logic [RATE_W-1:0]  short_new_r, short_new_nxt;
  logic [RATE_W-1:0]  avg_new_r, avg_new_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0] out_index_r, out_index_nxt;
  logic [RATE_W-1:0]  out_short_r, out_short_nxt;
  logic [RATE_W-1:0]  out_avg_r, out_avg_nxt;

  logic               accept;
  logic               commit;
  logic [FR_W-1:0]    f_eff;
  logic [WIN_W-1:0]   win;
  logic [INDEX_W-1:0] back;
  logic [DIV_W-1:0]   n_plus1;
  logic [BITS_W-1:0]  ram_rdata;
  logic [BITS_W-1:0]  old_bits;
  logic [ST_W-1:0]    st_sum;
  logic [ST_W:0]      st_diff;
  logic [MCAND_W-1:0] s_val;

  fbm_cmd_t           alu_cmd;
  fbm_res_t           alu_res;

  assign accept = in_ch.valid && in_ch.ready;
  assign commit = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // Window length in frames and ring slot of the frame leaving the window
  assign f_eff   = (frame_rate_r == '0) ? FR_W'(1) : frame_rate_r;
  assign win     = WIN_W'(DURATION) * WIN_W'(f_eff);
  assign back    = frame_count_r - INDEX_W'(win);
  assign n_plus1 = DIV_W'(frame_count_r) + DIV_W'(1);

  // Short-term sum: previous rate scaled by the window, plus new, minus old
  assign old_bits = sub_r ? ram_rdata : '0;
  assign st_sum   = ST_W'(short_r) * ST_W'(DURATION) + ST_W'(bits_r);
  assign st_diff  = {1'b0, st_sum} - (ST_W + 1)'(old_bits);

  assign s_val = MCAND_W'(alu_res.value[RATE_W+INDEX_W-1:0]) + MCAND_W'(bits_r);

  fbm_ram #(
    .DW (BITS_W),
    .AW (HIST_AW)
  ) u_hist (
    .clk   (clk),
    .we    (commit),
    .waddr (frame_count_r[HIST_AW-1:0]),
    .wdata (bits_r),
    .re    (accept),
    .raddr (back[HIST_AW-1:0]),
    .rdata (ram_rdata)
  );

  fbm_serial_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (alu_cmd),
    .res   (alu_res)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_ch.valid) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_MUL1;
      ST_MUL1: if (alu_res.done) state_nxt = ST_DIV1;
      ST_DIV1: if (alu_res.done) state_nxt = ST_MUL2;
      ST_MUL2: if (alu_res.done) state_nxt = ST_DIV2;
      ST_DIV2: begin
        if (alu_res.done) begin
          state_nxt = (DURATION != 1) ? ST_SDIV : ST_DONE;
        end
      end
      ST_SDIV: if (alu_res.done) state_nxt = ST_DONE;
      ST_DONE: if (commit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Unit commands and datapath updates
  always_comb begin
    alu_cmd         = '0;
    alu_cmd.op      = OP_MUL;
    bits_nxt        = bits_r;
    f_nxt           = f_r;
    p_nxt           = p_r;
    c_nxt           = c_r;
    sub_nxt         = sub_r;
    st_nxt          = st_r;
    short_new_nxt   = short_new_r;
    avg_new_nxt     = avg_new_r;
    frame_count_nxt = frame_count_r;
    short_nxt       = short_r;
    avg_nxt         = avg_r;
    out_index_nxt   = out_index_r;
    out_short_nxt   = out_short_r;
    out_avg_nxt     = out_avg_r;
    out_valid_nxt   = (out_valid_r && out_ch.ready) ? 1'b0 : out_valid_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          bits_nxt = in_ch.frame_bits;
          f_nxt    = f_eff;
          p_nxt    = (frame_count_r > INDEX_W'(win)) ? frame_count_r : INDEX_W'(win);
          c_nxt    = (n_plus1 > DIV_W'(win)) ? n_plus1 : DIV_W'(win);
          sub_nxt  = frame_count_r >= INDEX_W'(win);
        end
      end
      ST_LOAD: begin
        // clamp a negative sum to zero
        st_nxt        = st_diff[ST_W] ? '0 : st_diff[ST_W-1:0];
        short_new_nxt = st_diff[ST_W] ? '0 : fbm_sat(ACC_W'(st_diff[ST_W-1:0]));
        alu_cmd.start = 1'b1;
        alu_cmd.op    = OP_MUL;
        alu_cmd.steps = MUL1_STEPS;
        alu_cmd.opa   = ACC_W'(p_r);
        alu_cmd.opb   = {avg_r, {(DIV_W - RATE_W){1'b0}}};
      end
      ST_MUL1: begin
        if (alu_res.done) begin
          alu_cmd.start = 1'b1;
          alu_cmd.op    = OP_DIV;
          alu_cmd.steps = DIV1_STEPS;
          alu_cmd.opa   = {alu_res.value[RATE_W+INDEX_W-1:0],
                           {(ACC_W - RATE_W - INDEX_W){1'b0}}};
          alu_cmd.opb   = DIV_W'(f_r);
        end
      end
      ST_DIV1: begin
        if (alu_res.done) begin
          alu_cmd.start = 1'b1;
          alu_cmd.op    = OP_MUL;
          alu_cmd.steps = MUL2_STEPS;
          alu_cmd.opa   = ACC_W'(s_val);
          alu_cmd.opb   = {f_r, {(DIV_W - FR_W){1'b0}}};
        end
      end
      ST_MUL2: begin
        if (alu_res.done) begin
          alu_cmd.start = 1'b1;
          alu_cmd.op    = OP_DIV;
          alu_cmd.steps = DIV2_STEPS;
          alu_cmd.opa   = alu_res.value;
          alu_cmd.opb   = c_r;
        end
      end
      ST_DIV2: begin
        if (alu_res.done) begin
          avg_new_nxt = fbm_sat(alu_res.value);
          if (DURATION != 1) begin
            alu_cmd.start = 1'b1;
            alu_cmd.op    = OP_DIV;
            alu_cmd.steps = SDIV_STEPS;
            alu_cmd.opa   = {st_r, {(ACC_W - ST_W){1'b0}}};
            alu_cmd.opb   = DIV_W'(DURATION);
          end
        end
      end
      ST_SDIV: begin
        if (alu_res.done) begin
          short_new_nxt = fbm_sat(alu_res.value);
        end
      end
      ST_DONE: begin
        if (commit) begin
          out_valid_nxt   = 1'b1;
          out_index_nxt   = frame_count_r;
          out_short_nxt   = short_new_r;
          out_avg_nxt     = avg_new_r;
          short_nxt       = short_new_r;
          avg_nxt         = avg_new_r;
          frame_count_nxt = frame_count_r + INDEX_W'(1);
        end
      end
      default: begin
        alu_cmd.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      frame_rate_r  <= FR_RESET;
      frame_count_r <= '0;
      short_r       <= '0;
      avg_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      if (cfg_we) begin
        frame_rate_r <= cfg_wdata;
      end
      frame_count_r <= frame_count_nxt;
      short_r       <= short_nxt;
      avg_r         <= avg_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r      <= bits_nxt;
    f_r         <= f_nxt;
    p_r         <= p_nxt;
    c_r         <= c_nxt;
    sub_r       <= sub_nxt;
    st_r        <= st_nxt;
    short_new_r <= short_new_nxt;
    avg_new_r   <= avg_new_nxt;
    out_index_r <= out_index_nxt;
    out_short_r <= out_short_nxt;
    out_avg_r   <= out_avg_nxt;
  end

  assign in_ch.ready            = (state_r == ST_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.frame_index     = out_index_r;
  assign out_ch.short_term_rate = out_short_r;
  assign out_ch.average_rate    = out_avg_r;

  // The unit never gets a new command while still working
  a_start_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
    alu_cmd.start |-> !alu_res.busy)
    else $error("serial unit started while busy");

  // No new item is taken while the unit is still working
  a_busy_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    alu_res.busy |-> (state_r != ST_IDLE && state_r != ST_DONE))
    else $error("serial unit busy outside an arithmetic state");

  // A finished operation is always picked up by a waiting state
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    alu_res.done |-> (state_r == ST_MUL1 || state_r == ST_DIV1 || state_r == ST_MUL2 ||
                      state_r == ST_DIV2 || state_r == ST_SDIV))
    else $error("serial unit result with no consumer");

  // Each committed item advances the frame counter by one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> frame_count_r == $past(frame_count_r) + INDEX_W'(1))
    else $error("frame counter did not advance on commit");

endmodule

`default_nettype wire

// ===== test/frame_bitrate_meter_tb.sv =====
// Self-checking testbench for frame_bitrate_meter: feeds frame bit counts,
// predicts frame index, short-term and average rate, and checks each result.
// Depends on fbm_pkg and the channel interfaces in fbm_if.sv.
`timescale 1ns / 1ps

module frame_bitrate_meter_tb import fbm_pkg::*; ();

  localparam int CLK_HALF = 4;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [BITS_W-1:0] BITS_MAX = {BITS_W{1'b1}};
  localparam logic [FR_W-1:0] FR_ZERO = '0;
  localparam logic [FR_W-1:0] FR_ONE = FR_W'(1);
  localparam logic [FR_W-1:0] FR_TWO = FR_W'(2);
  localparam logic [FR_W-1:0] FR_TOP = FR_W'(240);
  localparam logic [FR_W-1:0] FR_FULL = FR_W'(255);

  typedef enum int {
    MIX_ANY,
    MIX_HIGH,
    MIX_LOW
  } bits_mix_t;

  typedef struct {
    logic [INDEX_W-1:0] index;
    logic [RATE_W-1:0]  short_rate;
    logic [RATE_W-1:0]  avg_rate;
  } rate_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [FR_W-1:0] cfg_wdata;

  fbm_in_if  frames_if ();
  fbm_out_if rates_if ();

  frame_bitrate_meter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (frames_if),
    .out_ch    (rates_if)
  );

  always #CLK_HALF clk = ~clk;

  // Predictor state
  logic [BITS_W-1:0]  bits_ring [WINDOW_DEPTH];
  logic [RATE_W-1:0]  short_rate_q;
  logic [RATE_W-1:0]  avg_rate_q;
  logic [INDEX_W-1:0] frames_seen;
  logic [FR_W-1:0]    rate_setting;

  rate_result_t pending_rates[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int gap_max = 0;
  int stall_max = 0;
  int burst_left = 0;
  int stall_left = 0;

  // Update the predicted meter state with one frame and return its rates.
  function automatic rate_result_t advance_meter(input logic [BITS_W-1:0] bits);
    rate_result_t res;
    longint unsigned fps, win, n, p, c;
    logic [95:0] avg_sum, avg_full;
    longint st;
    fps = (rate_setting == FR_ZERO) ? 1 : longint'(rate_setting);
    win = DURATION * fps;
    n = longint'(frames_seen);
    p = (n > win) ? n : win;
    c = (n + 1 > win) ? n + 1 : win;
    avg_sum = (96'(avg_rate_q) * 96'(p)) / 96'(fps) + 96'(bits);
    avg_full = (avg_sum * 96'(fps)) / 96'(c);
    st = longint'(short_rate_q) * DURATION + longint'(bits);
    if (n >= win) begin
      st -= longint'(bits_ring[int'((n - win) % WINDOW_DEPTH)]);
    end
    if (st < 0) begin
      st = 0;
    end
    st = st / DURATION;
    short_rate_q = (st > longint'(RATE_MAX)) ? RATE_MAX : st[RATE_W-1:0];
    avg_rate_q = (|avg_full[95:RATE_W]) ? RATE_MAX : avg_full[RATE_W-1:0];
    bits_ring[int'(n % WINDOW_DEPTH)] = bits;
    res.index = frames_seen;
    res.short_rate = short_rate_q;
    res.avg_rate = avg_rate_q;
    frames_seen = frames_seen + 1'b1;
    return res;
  endfunction

  // Send one frame item; leaves valid high so a following burst item needs no gap.
  task automatic send_frame(input logic [BITS_W-1:0] bits);
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        frames_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    frames_if.valid = 1'b1;
    frames_if.frame_bits = bits;
    do @(posedge clk); while (frames_if.ready !== 1'b1);
    pending_rates.push_back(advance_meter(bits));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    frames_if.valid = 1'b0;
    burst_left = 0;
    while (pending_rates.size() != 0) @(posedge clk);
  endtask

  task automatic write_frame_rate(input logic [FR_W-1:0] rate);
    wait_drained();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = rate;
    @(negedge clk);
    cfg_we = 1'b0;
    rate_setting = rate;
  endtask

  // Window of one frame, then widen it so the dropped frame exceeds the sum.
  task automatic test_negative_short_rate();
    gap_max = 0;
    stall_max = 0;
    write_frame_rate(FR_ONE);
    send_frame(BITS_MAX);
    send_frame('0);
    write_frame_rate(FR_TWO);
    send_frame('0);
    send_frame(BITS_W'(1));
  endtask

  task automatic test_zero_frame_rate();
    write_frame_rate(FR_ZERO);
    send_frame(BITS_MAX);
    send_frame('0);
    send_frame(BITS_MAX);
  endtask

  task automatic test_field_extremes();
    write_frame_rate(FR_RESET);
    send_frame('0);
    send_frame(BITS_MAX);
    send_frame(BITS_W'(1));
    send_frame({BITS_W/2{2'b10}});
    send_frame({BITS_W/2{2'b01}});
    send_frame(BITS_W'(1) << (BITS_W - 1));
    send_frame(BITS_MAX);
    send_frame('0);
  endtask

  task automatic test_wide_frame_rates();
    write_frame_rate(FR_FULL);
    send_frame(BITS_MAX);
    send_frame(BITS_MAX);
    send_frame('0);
    write_frame_rate(FR_TOP);
    send_frame(BITS_MAX);
    send_frame(BITS_W'(12345));
    send_frame('0);
  endtask

  task automatic test_random_frames(input logic [FR_W-1:0] rate, input int count,
                                    input int gap_limit, input int stall_limit,
                                    input bits_mix_t mix);
    logic [BITS_W-1:0] bits;
    int pick;
    write_frame_rate(rate);
    gap_max = gap_limit;
    stall_max = stall_limit;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 7);
      case (mix)
        MIX_HIGH: begin
          bits = (pick == 0) ? BITS_W'($urandom) : BITS_MAX - BITS_W'($urandom_range(0, 4095));
        end
        MIX_LOW: begin
          bits = (pick == 0) ? BITS_W'($urandom) : BITS_W'($urandom_range(0, 1023));
        end
        default: begin
          case (pick)
            0: bits = '0;
            1: bits = BITS_MAX;
            2, 3: bits = BITS_W'($urandom_range(0, 1023));
            default: bits = BITS_W'($urandom);
          endcase
        end
      endcase
      send_frame(bits);
    end
  endtask

  // Receiver: mostly ready, with stalls of random length started at random
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      rates_if.ready <= 1'b0;
    end else if (stall_max != 0 && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, stall_max) - 1;
      rates_if.ready <= 1'b0;
    end else begin
      rates_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_rates
    rate_result_t want;
    if (rst_n === 1'b1 && rates_if.valid === 1'b1 && rates_if.ready === 1'b1) begin
      if (pending_rates.size() == 0) begin
        $error("unexpected result item: frame_index %0d", rates_if.frame_index);
        error_count++;
      end else begin
        want = pending_rates.pop_front();
        if (rates_if.frame_index !== want.index) begin
          $error("frame_index: expected %0d, got %0d", want.index, rates_if.frame_index);
          error_count++;
        end
        if (rates_if.short_term_rate !== want.short_rate) begin
          $error("short_term_rate: expected %0d, got %0d", want.short_rate,
                 rates_if.short_term_rate);
          error_count++;
        end
        if (rates_if.average_rate !== want.avg_rate) begin
          $error("average_rate: expected %0d, got %0d", want.avg_rate,
                 rates_if.average_rate);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    frames_if.valid = 1'b0;
    frames_if.frame_bits = '0;
    rates_if.ready = 1'b0;
    short_rate_q = '0;
    avg_rate_q = '0;
    frames_seen = '0;
    rate_setting = FR_RESET;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      bits_ring[i] = '0;
    end
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_negative_short_rate();
    test_zero_frame_rate();
    test_field_extremes();
    test_wide_frame_rates();

    test_random_frames(FR_RESET, 300, 0, 0, MIX_ANY);
    test_random_frames(FR_ONE, 150, 250, 40, MIX_ANY);
    // drive both rates into saturation, then let the window drain
    test_random_frames(FR_FULL, 300, 60, 200, MIX_HIGH);
    test_random_frames(FR_TOP, 250, 20, 8, MIX_LOW);
    test_random_frames(FR_W'($urandom_range(2, 239)), 200, 120, 20, MIX_ANY);
    test_random_frames(FR_ZERO, 100, 30, 60, MIX_ANY);
    test_random_frames(FR_RESET, 100, 250, 100, MIX_HIGH);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
